// ===== rtl/assert_macros.svh =====
// assertion helpers, compiled out when ASSERT_OFF is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expression holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error("assertion failed");

// consequence holds in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_NEXT(label, clk, rst_n, cond, cons)

`endif

`endif

// ===== rtl/txd_pkg.sv =====
package txd_pkg;

    localparam int DATA_W       = 8;
    localparam int VALUE_W      = 64;
    localparam int ENTRY_W      = 32;
    localparam int WORD_W       = 2;
    localparam int HASH_BYTES   = 32;
    localparam int ID_WORDS     = HASH_BYTES / 8;
    localparam int FIELD_BYTES  = 4;
    localparam int AMOUNT_BYTES = 8;

    localparam int REC_MAX = 4;
    localparam int REC_CW  = $clog2(REC_MAX + 1);
    localparam int REC_IW  = $clog2(REC_MAX);
    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [DATA_W-1:0] VARINT_16 = 8'hFD;
    localparam logic [DATA_W-1:0] VARINT_32 = 8'hFE;

    typedef enum logic [2:0] {
        KIND_VERSION   = 3'd0,
        KIND_IN_COUNT  = 3'd1,
        KIND_PREV_ID   = 3'd2,
        KIND_PREV_IDX  = 3'd3,
        KIND_SEQUENCE  = 3'd4,
        KIND_OUT_COUNT = 3'd5,
        KIND_AMOUNT    = 3'd6,
        KIND_LOCKTIME  = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind                record_kind;
        logic [VALUE_W-1:0]   value;
        logic [ENTRY_W-1:0]   entry_index;
        logic [WORD_W-1:0]    word_index;
        logic                 last_of_run;
        logic                 tx_done;
    } t_rec;

    function automatic t_rec mk_rec(t_kind kind, logic [VALUE_W-1:0] value,
                                    logic [ENTRY_W-1:0] entry, logic [WORD_W-1:0] word,
                                    logic last, logic done);
        t_rec r;
        r.record_kind = kind;
        r.value       = value;
        r.entry_index = entry;
        r.word_index  = word;
        r.last_of_run = last;
        r.tx_done     = done;
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] bswap64(logic [VALUE_W-1:0] x);
        logic [VALUE_W-1:0] r;
        for (int k = 0; k < VALUE_W / 8; k++) begin
            r[8*k +: 8] = x[VALUE_W - 8 - 8*k +: 8];
        end
        return r;
    endfunction

endpackage

// ===== rtl/txd_in_if.sv =====
interface txd_in_if import txd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_byte;
    logic              start_of_tx;

    modport source (output valid, output data_byte, output start_of_tx, input ready);
    modport sink   (input valid, input data_byte, input start_of_tx, output ready);
endinterface

// ===== rtl/txd_out_if.sv =====
interface txd_out_if import txd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         record_kind;
    logic [VALUE_W-1:0] value;
    logic [ENTRY_W-1:0] entry_index;
    logic [WORD_W-1:0]  word_index;
    logic               last_of_run;
    logic               tx_done;

    modport source (output valid, output record_kind, output value, output entry_index,
                    output word_index, output last_of_run, output tx_done, input ready);
    modport sink   (input valid, input record_kind, input value, input entry_index,
                    input word_index, input last_of_run, input tx_done, output ready);
endinterface

// ===== rtl/tx_stream_deserializer_core.sv =====
// Streaming decoder for a serialized legacy transaction, one byte per request on i_in.
// Each decoded field (version, counts, previous id words, index, sequence, amount,
// locktime) leaves on o_out as one record; script bytes are skipped and a completed
// previous id leaves as four 64-bit word records of the reversed id, queued together.
// The block takes one byte every cycle while decoding does not wait. A byte passes an
// input register, is decoded from that register and is written to an eight-entry
// result queue that drives o_out. Decoding of a byte waits only while fewer than four
// queue entries are free, which happens only when the sink stalls; then i_in.ready
// drops until room returns.
// A byte with start_of_tx high restarts decoding as the first version byte; bytes
// after the locktime produce nothing until such a restart.
`include "assert_macros.svh"

module tx_stream_deserializer_core import txd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    txd_in_if.sink      i_in,
    txd_out_if.source   o_out
);

    typedef enum logic [3:0] {
        PH_VERSION        = 4'd0,
        PH_IN_COUNT       = 4'd1,
        PH_PREV_ID        = 4'd2,
        PH_PREV_IDX       = 4'd3,
        PH_IN_SCRIPT_LEN  = 4'd4,
        PH_IN_SCRIPT      = 4'd5,
        PH_SEQUENCE       = 4'd6,
        PH_OUT_COUNT      = 4'd7,
        PH_AMOUNT         = 4'd8,
        PH_OUT_SCRIPT_LEN = 4'd9,
        PH_OUT_SCRIPT     = 4'd10,
        PH_LOCKTIME       = 4'd11,
        PH_DONE           = 4'd12
    } t_phase;

    // input register
    logic              r_in_valid;
    logic [DATA_W-1:0] r_in_byte;
    logic              r_in_start;

    // parser state
    t_phase             r_phase,   n_phase,   cur_phase;
    logic [5:0]         r_cnt,     n_cnt,     cur_cnt;
    logic [3:0]         r_vlen,    n_vlen,    cur_vlen;
    logic [VALUE_W-1:0] r_acc,     n_acc,     cur_acc;
    logic [VALUE_W-1:0] r_in_rem,  n_in_rem,  cur_in_rem;
    logic [VALUE_W-1:0] r_out_rem, n_out_rem, cur_out_rem;
    logic [VALUE_W-1:0] r_script,  n_script,  cur_script;
    logic [ENTRY_W-1:0] r_entry,   n_entry,   cur_entry;
    logic [HASH_BYTES*8-1:0] r_id, id_full;

    logic [5:0]         feed_cnt;
    logic [VALUE_W-1:0] feed_acc;
    logic               var_first;
    logic               var_done;
    logic [VALUE_W-1:0] var_val;
    logic [3:0]         var_len;
    logic [VALUE_W-1:0] dec_in_rem, dec_out_rem, dec_script;

    t_rec              rec [REC_MAX];
    logic [REC_CW-1:0] rec_cnt;

    // result queue
    t_rec              r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic [Q_DEPTH-1:0] q_we;
    t_rec              q_wdata [Q_DEPTH];
    logic              s2_fire;
    logic              in_fire;
    logic              pop;
    logic [REC_CW-1:0] push_cnt;

    assign s2_fire  = r_in_valid && (r_count <= (Q_AW+1)'(Q_DEPTH - REC_MAX));
    assign i_in.ready = !r_in_valid || s2_fire;
    assign in_fire  = i_in.valid && i_in.ready;
    assign pop      = o_out.valid && o_out.ready;
    assign push_cnt = s2_fire ? rec_cnt : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (s2_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte  <= i_in.data_byte;
            r_in_start <= i_in.start_of_tx;
        end
    end

    // decode of the registered byte
    always_comb begin
        cur_phase   = r_phase;
        cur_cnt     = r_cnt;
        cur_vlen    = r_vlen;
        cur_acc     = r_acc;
        cur_in_rem  = r_in_rem;
        cur_out_rem = r_out_rem;
        cur_script  = r_script;
        cur_entry   = r_entry;
        if (r_in_start) begin
            cur_phase   = PH_VERSION;
            cur_cnt     = '0;
            cur_vlen    = '0;
            cur_acc     = '0;
            cur_in_rem  = '0;
            cur_out_rem = '0;
            cur_script  = '0;
            cur_entry   = '0;
        end

        feed_cnt = cur_cnt + 6'd1;
        feed_acc = cur_acc;
        for (int l = 0; l < VALUE_W / 8; l++) begin
            if (cur_cnt[2:0] == 3'(l)) begin
                feed_acc[8*l +: 8] = cur_acc[8*l +: 8] | r_in_byte;
            end
        end

        var_first = (cur_vlen == '0);
        var_done  = var_first ? (r_in_byte < VARINT_16) : (feed_cnt >= {2'b00, cur_vlen});
        var_val   = var_first ? {{(VALUE_W-DATA_W){1'b0}}, r_in_byte} : feed_acc;
        var_len   = (r_in_byte == VARINT_16) ? 4'd2 : ((r_in_byte == VARINT_32) ? 4'd4 : 4'd8);

        id_full     = {r_id[HASH_BYTES*8-DATA_W-1:0], r_in_byte};
        dec_in_rem  = cur_in_rem - 64'd1;
        dec_out_rem = cur_out_rem - 64'd1;
        dec_script  = cur_script - 64'd1;

        n_phase   = cur_phase;
        n_cnt     = cur_cnt;
        n_vlen    = cur_vlen;
        n_acc     = cur_acc;
        n_in_rem  = cur_in_rem;
        n_out_rem = cur_out_rem;
        n_script  = cur_script;
        n_entry   = cur_entry;
        rec_cnt   = '0;
        for (int k = 0; k < REC_MAX; k++) begin
            rec[k] = '0;
        end

        unique case (cur_phase) inside
            PH_VERSION, PH_PREV_IDX, PH_SEQUENCE, PH_AMOUNT, PH_LOCKTIME: begin
                if (feed_cnt >= ((cur_phase == PH_AMOUNT) ? 6'(AMOUNT_BYTES)
                                                          : 6'(FIELD_BYTES))) begin
                    rec_cnt = REC_CW'(1);
                    n_cnt   = '0;
                    n_vlen  = '0;
                    n_acc   = '0;
                    case (cur_phase)
                        PH_VERSION: begin
                            rec[0]  = mk_rec(KIND_VERSION, feed_acc, '0, '0, 1'b1, 1'b0);
                            n_phase = PH_IN_COUNT;
                        end
                        PH_PREV_IDX: begin
                            rec[0]  = mk_rec(KIND_PREV_IDX, feed_acc, cur_entry, '0,
                                             1'b1, 1'b0);
                            n_phase = PH_IN_SCRIPT_LEN;
                        end
                        PH_SEQUENCE: begin
                            rec[0]   = mk_rec(KIND_SEQUENCE, feed_acc, cur_entry, '0,
                                              1'b1, 1'b0);
                            n_entry  = cur_entry + 32'd1;
                            n_in_rem = dec_in_rem;
                            n_phase  = (dec_in_rem != '0) ? PH_PREV_ID : PH_OUT_COUNT;
                        end
                        PH_AMOUNT: begin
                            rec[0]  = mk_rec(KIND_AMOUNT, feed_acc, cur_entry, '0,
                                             1'b1, 1'b0);
                            n_phase = PH_OUT_SCRIPT_LEN;
                        end
                        default: begin
                            rec[0]  = mk_rec(KIND_LOCKTIME, feed_acc, '0, '0, 1'b1, 1'b1);
                            n_phase = PH_DONE;
                        end
                    endcase
                end else begin
                    n_cnt = feed_cnt;
                    n_acc = feed_acc;
                end
            end
            PH_IN_COUNT, PH_IN_SCRIPT_LEN, PH_OUT_COUNT, PH_OUT_SCRIPT_LEN: begin
                if (var_done) begin
                    n_cnt  = '0;
                    n_vlen = '0;
                    n_acc  = '0;
                    case (cur_phase)
                        PH_IN_COUNT: begin
                            rec_cnt  = REC_CW'(1);
                            rec[0]   = mk_rec(KIND_IN_COUNT, var_val, '0, '0, 1'b1, 1'b0);
                            n_in_rem = var_val;
                            n_entry  = '0;
                            n_phase  = (var_val != '0) ? PH_PREV_ID : PH_OUT_COUNT;
                        end
                        PH_OUT_COUNT: begin
                            rec_cnt   = REC_CW'(1);
                            rec[0]    = mk_rec(KIND_OUT_COUNT, var_val, '0, '0, 1'b1, 1'b0);
                            n_out_rem = var_val;
                            n_entry   = '0;
                            n_phase   = (var_val != '0) ? PH_AMOUNT : PH_LOCKTIME;
                        end
                        PH_IN_SCRIPT_LEN: begin
                            n_script = var_val;
                            n_phase  = (var_val != '0) ? PH_IN_SCRIPT : PH_SEQUENCE;
                        end
                        default: begin
                            n_script = var_val;
                            if (var_val != '0) begin
                                n_phase = PH_OUT_SCRIPT;
                            end else begin
                                n_entry   = cur_entry + 32'd1;
                                n_out_rem = dec_out_rem;
                                n_phase   = (dec_out_rem != '0) ? PH_AMOUNT : PH_LOCKTIME;
                            end
                        end
                    endcase
                end else if (var_first) begin
                    n_vlen = var_len;
                    n_cnt  = '0;
                    n_acc  = '0;
                end else begin
                    n_cnt = feed_cnt;
                    n_acc = feed_acc;
                end
            end
            PH_PREV_ID: begin
                n_cnt = feed_cnt;
                if (feed_cnt >= 6'(HASH_BYTES)) begin
                    for (int w = 0; w < ID_WORDS; w++) begin
                        rec[w] = mk_rec(KIND_PREV_ID, bswap64(id_full[VALUE_W*w +: VALUE_W]),
                                        cur_entry, WORD_W'(w), (w == ID_WORDS - 1), 1'b0);
                    end
                    rec_cnt = REC_CW'(ID_WORDS);
                    n_cnt   = '0;
                    n_vlen  = '0;
                    n_acc   = '0;
                    n_phase = PH_PREV_IDX;
                end
            end
            PH_IN_SCRIPT: begin
                n_script = dec_script;
                if (dec_script == '0) begin
                    n_phase = PH_SEQUENCE;
                end
            end
            PH_OUT_SCRIPT: begin
                n_script = dec_script;
                if (dec_script == '0) begin
                    n_cnt     = '0;
                    n_vlen    = '0;
                    n_acc     = '0;
                    n_entry   = cur_entry + 32'd1;
                    n_out_rem = dec_out_rem;
                    n_phase   = (dec_out_rem != '0) ? PH_AMOUNT : PH_LOCKTIME;
                end
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = cur_phase;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_VERSION;
            r_cnt     <= '0;
            r_vlen    <= '0;
            r_acc     <= '0;
            r_in_rem  <= '0;
            r_out_rem <= '0;
            r_script  <= '0;
            r_entry   <= '0;
        end else if (s2_fire) begin
            r_phase   <= n_phase;
            r_cnt     <= n_cnt;
            r_vlen    <= n_vlen;
            r_acc     <= n_acc;
            r_in_rem  <= n_in_rem;
            r_out_rem <= n_out_rem;
            r_script  <= n_script;
            r_entry   <= n_entry;
        end
    end

    // id bytes shift in, newest at the bottom
    always_ff @(posedge i_clk) begin
        if (s2_fire && (cur_phase == PH_PREV_ID)) begin
            r_id <= id_full;
        end
    end

    // queue write steering
    always_comb begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            logic [Q_AW-1:0] off;
            off        = Q_AW'(i) - r_wr_ptr;
            q_we[i]    = s2_fire && ({1'b0, off} < (Q_AW+1)'(rec_cnt));
            q_wdata[i] = rec[off[REC_IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Q_DEPTH; i++) begin
            if (q_we[i]) begin
                r_q[i] <= q_wdata[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + Q_AW'(push_cnt);
            r_rd_ptr <= r_rd_ptr + Q_AW'(pop);
            r_count  <= r_count + (Q_AW+1)'(push_cnt) - (Q_AW+1)'(pop);
        end
    end

    assign o_out.valid       = (r_count != '0);
    assign o_out.record_kind = r_q[r_rd_ptr].record_kind;
    assign o_out.value       = r_q[r_rd_ptr].value;
    assign o_out.entry_index = r_q[r_rd_ptr].entry_index;
    assign o_out.word_index  = r_q[r_rd_ptr].word_index;
    assign o_out.last_of_run = r_q[r_rd_ptr].last_of_run;
    assign o_out.tx_done     = r_q[r_rd_ptr].tx_done;

    `ASSERT_ALWAYS(a_q_bound, i_clk, i_rst_n, r_count <= (Q_AW+1)'(Q_DEPTH))
    `ASSERT_ALWAYS(a_q_empty_ptrs, i_clk, i_rst_n, r_count != '0 || r_wr_ptr == r_rd_ptr)
    `ASSERT_ALWAYS(a_burst_is_id, i_clk, i_rst_n,
                   !(s2_fire && rec_cnt > REC_CW'(1)) || rec[0].record_kind == KIND_PREV_ID)
    `ASSERT_NEXT(a_done_phase, i_clk, i_rst_n,
                 s2_fire && rec_cnt != '0 && rec[0].tx_done, r_phase == PH_DONE)
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n,
                 r_in_valid && !s2_fire, r_in_valid && $stable(r_in_byte))

endmodule
